/* hdl/hcbd_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// hcbd_pkg
// Shared types and constants for the chunked body decoder.
// ============================================================================
package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int BYTE_W      = 8;
    localparam int DROP_W      = 32;
    localparam int STAT_W      = 2;

    localparam int OUT_BYTE_LSB = 0;
    localparam int OUT_STAT_LSB = OUT_BYTE_LSB + BYTE_W;
    localparam int OUT_DROP_LSB = OUT_STAT_LSB + STAT_W;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_DROP_LSB - DROP_W;

    typedef enum logic [STAT_W-1:0] {
        ST_ZERO      = 2'd0,
        ST_BETWEEN   = 2'd1,
        ST_CUT       = 2'd2,
        ST_MALFORMED = 2'd3
    } t_end_status;

    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SP    = 8'h20;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_9     = 8'h39;
    localparam logic [7:0] CHR_UA    = 8'h41;
    localparam logic [7:0] CHR_UF    = 8'h46;
    localparam logic [7:0] CHR_UX    = 8'h58;
    localparam logic [7:0] CHR_LA    = 8'h61;
    localparam logic [7:0] CHR_LCF   = 8'h66;
    localparam logic [7:0] CHR_LX    = 8'h78;

endpackage

/* hdl/http_chunked_body_decoder_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// http_chunked_body_decoder_unit
// Chunked transfer body decoder: size lines parsed as base-16 numbers,
// payload words passed on, end status and drop count on the last word.
// ============================================================================
//  channel  | dir | tdata                               | tuser    | tlast
//  s_axis   | in  | [7:0] body byte                     | -        | end of body
//  m_axis   | out | [7:0] byte, [9:8] status, [41:10]   | has data | body done
//           |     | drop count, [47:42] zero            |          |
//
//  One word per clock sustained; input register then result register, so a
//  result is registered from its word as that word leaves the input register.
//  Words that produce nothing (size line, trailer skip) leave no result.
//  Decoder state is updated once per word taken from the input register.
//  i_rst_n is synchronous, active low; a stalled m_axis stalls s_axis.
// ============================================================================
module http_chunked_body_decoder_unit
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic                   i_s_axis_tlast,   // end_of_body
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // data_byte, end_status, drop_count
    output logic                   o_m_axis_tuser,   // has_data
    output logic                   o_m_axis_tlast    // body_done
);

    typedef enum logic [2:0] {
        PH_LEAD, PH_SIGN, PH_ZERO, PH_DIGITS, PH_REST, PH_DATA, PH_SKIP, PH_DONE
    } t_phase;

    // input stage
    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_in_last;

    // decoder state
    t_phase              r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_accum, n_accum;
    logic [SIZE_BITS-1:0] r_left, n_left;
    logic [SIZE_BITS-1:0] r_emitted, n_emitted;
    logic                r_pending, n_pending;
    logic [1:0]          r_skip, n_skip;
    logic                r_minus, n_minus;
    t_end_status         r_final, n_final;

    // result stage
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_has;
    logic                r_out_last;
    t_end_status         r_out_stat;
    logic [DROP_W-1:0]   r_out_drop;

    logic                adv;
    logic                take;
    logic                emit;
    t_end_status         stat;
    logic [DROP_W-1:0]   drop;
    logic [63:0]         emitted_wide;
    t_phase              ph_a;
    logic                line_done;
    logic                is_digit;
    logic [3:0]          digit;
    logic [SIZE_BITS+3:0] acc_sum;
    logic [SIZE_BITS-1:0] acc_next;
    logic                is_space;

    assign adv             = !r_out_valid || i_m_axis_tready;
    assign take            = r_in_valid && adv;
    assign o_s_axis_tready = !r_in_valid || adv;

    always_comb begin
        is_digit = 1'b0;
        digit    = 4'd0;
        if (r_in_byte >= CHR_0 && r_in_byte <= CHR_9) begin
            is_digit = 1'b1;
            digit    = r_in_byte[3:0];
        end else if ((r_in_byte >= CHR_LA && r_in_byte <= CHR_LCF) ||
                     (r_in_byte >= CHR_UA && r_in_byte <= CHR_UF)) begin
            is_digit = 1'b1;
            digit    = r_in_byte[3:0] + 4'd9;
        end
        is_space = (r_in_byte == CHR_SP) || (r_in_byte inside {[CHR_TAB:CHR_CR]});
        acc_sum  = {r_accum, 4'b0000} + (SIZE_BITS+4)'(digit);
        acc_next = (acc_sum[SIZE_BITS+3:SIZE_BITS] != 4'd0) ? '1 : acc_sum[SIZE_BITS-1:0];
    end

    always_comb begin
        n_phase   = r_phase;
        n_accum   = r_accum;
        n_left    = r_left;
        n_emitted = r_emitted;
        n_pending = r_pending;
        n_skip    = r_skip;
        n_minus   = r_minus;
        n_final   = r_final;
        emit      = 1'b0;
        line_done = 1'b0;
        ph_a      = r_phase;

        case (r_phase)
            PH_LEAD, PH_SIGN, PH_ZERO, PH_DIGITS, PH_REST: begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    if (r_in_byte == CHR_LF) begin
                        line_done = 1'b1;
                        if (r_minus) begin
                            n_phase = PH_DONE;
                            n_final = ST_MALFORMED;
                        end else if (r_accum == '0) begin
                            n_phase = PH_DONE;
                            n_final = ST_ZERO;
                        end else begin
                            n_left    = r_accum;
                            n_emitted = '0;
                            n_phase   = PH_DATA;
                        end
                    end else begin
                        // lone CR counts as a line character
                        ph_a = (r_phase == PH_LEAD) ? PH_LEAD : PH_REST;
                    end
                end
                if (!line_done) begin
                    n_phase = ph_a;
                    if (r_in_byte == CHR_CR) begin
                        n_pending = 1'b1;
                    end else begin
                        case (ph_a)
                            PH_LEAD, PH_SIGN: begin
                                if (ph_a == PH_LEAD && is_space) begin
                                    n_phase = PH_LEAD;
                                end else if (ph_a == PH_LEAD && r_in_byte == CHR_PLUS) begin
                                    n_phase = PH_SIGN;
                                end else if (ph_a == PH_LEAD && r_in_byte == CHR_MINUS) begin
                                    n_minus = 1'b1;
                                    n_phase = PH_SIGN;
                                end else if (r_in_byte == CHR_0) begin
                                    n_phase = PH_ZERO;
                                end else if (is_digit) begin
                                    n_accum = acc_next;
                                    n_phase = PH_DIGITS;
                                end else begin
                                    n_phase = PH_REST;
                                end
                            end
                            PH_ZERO, PH_DIGITS: begin
                                if (ph_a == PH_ZERO &&
                                    (r_in_byte == CHR_LX || r_in_byte == CHR_UX)) begin
                                    n_phase = PH_DIGITS;
                                end else if (is_digit) begin
                                    n_accum = acc_next;
                                    n_phase = PH_DIGITS;
                                end else begin
                                    n_phase = PH_REST;
                                end
                            end
                            default: begin
                                n_phase = ph_a;
                            end
                        endcase
                    end
                end
            end
            PH_DATA: begin
                emit      = 1'b1;
                n_left    = r_left - SIZE_BITS'(1);
                n_emitted = r_emitted + SIZE_BITS'(1);
                if (n_left == '0) begin
                    n_phase = PH_SKIP;
                    n_skip  = 2'd2;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 2'd1;
                if (n_skip == 2'd0) begin
                    n_phase = PH_LEAD;
                    n_accum = '0;
                    n_minus = 1'b0;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        emitted_wide = 64'(n_emitted);
        stat = ST_ZERO;
        drop = '0;
        if (r_in_last) begin
            if (n_phase == PH_DONE) begin
                stat = n_final;
            end else if (n_phase == PH_DATA) begin
                stat = ST_CUT;
                drop = (emitted_wide[63:DROP_W] != '0) ? '1 : emitted_wide[DROP_W-1:0];
            end else begin
                stat = ST_BETWEEN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_LEAD;
            r_accum     <= '0;
            r_left      <= '0;
            r_emitted   <= '0;
            r_pending   <= 1'b0;
            r_skip      <= 2'd0;
            r_minus     <= 1'b0;
            r_final     <= ST_ZERO;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
                r_in_byte  <= i_s_axis_tdata[BYTE_W-1:0];
                r_in_last  <= i_s_axis_tlast;
            end
            if (adv) begin
                r_out_valid <= take && (emit || r_in_last);
                r_out_byte  <= emit ? r_in_byte : '0;
                r_out_has   <= emit;
                r_out_last  <= r_in_last;
                r_out_stat  <= stat;
                r_out_drop  <= drop;
            end
            if (take) begin
                if (r_in_last) begin
                    r_phase   <= PH_LEAD;
                    r_accum   <= '0;
                    r_left    <= '0;
                    r_emitted <= '0;
                    r_pending <= 1'b0;
                    r_skip    <= 2'd0;
                    r_minus   <= 1'b0;
                    r_final   <= ST_ZERO;
                end else begin
                    r_phase   <= n_phase;
                    r_accum   <= n_accum;
                    r_left    <= n_left;
                    r_emitted <= n_emitted;
                    r_pending <= n_pending;
                    r_skip    <= n_skip;
                    r_minus   <= n_minus;
                    r_final   <= n_final;
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_drop, r_out_stat, r_out_byte};
    assign o_m_axis_tuser  = r_out_has;
    assign o_m_axis_tlast  = r_out_last;

endmodule

/* hdl/hcbd_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// hcbd_checker
// Port-level checks on the chunked body decoder's result stream.
// ============================================================================
module hcbd_checker
    import hcbd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   o_m_axis_tuser,
    input logic                   o_m_axis_tlast
);

    logic [STAT_W-1:0] stat;
    logic [DROP_W-1:0] drop;

    assign stat = o_m_axis_tdata[OUT_STAT_LSB +: STAT_W];
    assign drop = o_m_axis_tdata[OUT_DROP_LSB +: DROP_W];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("result word changed while stalled");

    a_word_has_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser || o_m_axis_tlast))
        else $error("result word with neither payload nor end of body");

    a_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
            (o_m_axis_tdata[OUT_BYTE_LSB +: BYTE_W] == '0))
        else $error("data byte set without payload");

    a_mid_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> (stat == ST_ZERO && drop == '0))
        else $error("end status before end of body");

    a_drop_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && stat != ST_CUT) |-> (drop == '0))
        else $error("drop count without a cut-short chunk");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
